FILE: hdl/rews_pkg.sv
// Package with shared constants, types and the cosine table for the restraint well scorer.
package rews_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COS_TABLE_DEPTH = 256;
  localparam int DIST_W = 23;
  localparam int BOND_W = 6;
  localparam int GAIN_W = 24;
  localparam int SCORE_W = 32;
  localparam int RW = DIST_W + 2;
  localparam int COS_W = FRAC_BITS + 1;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int OFF_W = 20;
  localparam int DEPTH_SH = $clog2(COS_TABLE_DEPTH);

  localparam logic signed [RW-1:0] Tenth = RW'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [RW-1:0] PreWidth = RW'(15 * (1 << FRAC_BITS));
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam logic signed [63:0] Q30 = 64'sd1073741824;

  typedef enum logic [1:0] {
    CFG_WELL_MODE  = 2'd0,
    CFG_LOWER_GAIN = 2'd1,
    CFG_UPPER_GAIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEG_FLAT,
    SEG_LOW_WALL,
    SEG_HIGH_WALL,
    SEG_HIGH_LINE,
    SEG_ONE,
    SEG_COS_RISE,
    SEG_COS_FALL
  } seg_e;

  typedef struct packed {
    logic                 inval;
    logic                 err;
    logic                 mode;
    logic [DIST_W-1:0]    x;
    logic signed [RW-1:0] r1;
    logic signed [RW-1:0] r2;
    logic signed [RW-1:0] r3;
    logic signed [RW-1:0] r4;
  } geom_t;

  typedef logic [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH+1];

  // Restoring shift and subtract division, used only while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Half cosine table, (1 + cos(pi*i/D)) / 2 in Q.16, from a Q30 Taylor series.
  function automatic cos_tab_t build_cos_table();
    cos_tab_t         tab;
    logic [63:0]      th;
    logic [63:0]      th2;
    logic [63:0]      t;
    logic [63:0]      j;
    logic signed [63:0] c;
    logic             neg;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      j = 64'(i);
      neg = 1'b0;
      if (2 * i > COS_TABLE_DEPTH) begin
        j = 64'(COS_TABLE_DEPTH - i);
        neg = 1'b1;
      end
      th = (PiQ30 * j) >> DEPTH_SH;
      th2 = (th * th) >> 30;
      c = Q30;
      t = 64'(Q30);
      for (int n = 1; n <= 12; n++) begin
        t = div_u64((t * th2) >> 30, 64'(2 * n - 1) * 64'(2 * n));
        if (n[0]) c = c - $signed(t);
        else c = c + $signed(t);
      end
      if (c > Q30) c = Q30;
      if (c < -Q30) c = -Q30;
      if (neg) c = -c;
      tab[i] = COS_W'(((64'(Q30 + c) << FRAC_BITS) + 64'(Q30)) >> 31);
    end
    return tab;
  endfunction

endpackage

FILE: hdl/rews_geom.sv
// First pipeline stage: bond shifted well boundaries and order check.
module rews_geom (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic                        mode_i,
  input  logic                        distance_valid_i,
  input  logic [rews_pkg::DIST_W-1:0] measured_distance_i,
  input  logic [rews_pkg::DIST_W-1:0] lower_bound_i,
  input  logic [rews_pkg::DIST_W-1:0] upper_bound_i,
  input  logic [rews_pkg::DIST_W-1:0] expected_distance_i,
  input  logic                        bond_valid_i,
  input  logic [rews_pkg::BOND_W-1:0] bond_count_i,
  output logic                        valid_o,
  output rews_pkg::geom_t             geom_o
);
  import rews_pkg::*;

  logic signed [RW-1:0] lo_s, up_s, ex_s, e_s, eh_s;
  logic signed [RW-1:0] t_n, r3_n, a4_n, b4_n, t_p;
  geom_t geom_d, geom_q;
  logic  valid_q;

  always_comb begin
    lo_s = RW'(lower_bound_i);
    up_s = RW'(upper_bound_i);
    ex_s = RW'(expected_distance_i);
    e_s  = RW'({bond_count_i, {FRAC_BITS{1'b0}}});
    eh_s = RW'({bond_count_i, {(FRAC_BITS-1){1'b0}}});
    t_n  = lo_s - e_s;
    r3_n = ex_s + e_s;
    a4_n = r3_n + Tenth;
    b4_n = up_s + e_s;
    t_p  = lo_s - eh_s;

    geom_d.inval = !distance_valid_i || !bond_valid_i;
    geom_d.mode  = mode_i;
    geom_d.x     = measured_distance_i;
    if (!mode_i) begin
      geom_d.r2 = (t_n < 0) ? '0 : t_n;
      // The lower line starts a tenth below r2 but never above zero.
      geom_d.r1 = geom_d.r2 - Tenth;
      if (geom_d.r1 > 0) geom_d.r1 = '0;
      geom_d.r3 = r3_n;
      geom_d.r4 = (b4_n < a4_n) ? a4_n : b4_n;
    end else begin
      geom_d.r2 = (t_p < 0) ? '0 : t_p;
      geom_d.r1 = geom_d.r2 - PreWidth;
      geom_d.r3 = up_s - eh_s;
      geom_d.r4 = geom_d.r3 + PreWidth;
    end
    // The outer boundaries always sit outside r2 and r3, so only r2 < r3 can fail.
    geom_d.err = !(geom_d.r2 < geom_d.r3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q <= geom_d;
    end
  end

  assign valid_o = valid_q;
  assign geom_o  = geom_q;

endmodule

FILE: hdl/restraint_energy_well_score_core.sv
// Top level of the restraint well scorer: five stage pipeline with output register.
//
// Input items arrive on in_valid_i / in_ready_o with one port per field; each
// item yields exactly one result item on out_valid_o / out_ready_i carrying
// score_o (signed Q15.16, well value minus one) and order_error_o.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i selects well mode,
// lower wall gain or upper wall gain, cfg_wdata_i holds the value.
// out_valid_o rises once an accepted item has passed through the five registers:
// boundary setup, segment selection, squaring multipliers, gain multipliers
// with table lookup, and the final sum with saturation into the output register.
// Throughput is one item per cycle; the whole pipeline advances together
// whenever the output register is empty or is being taken.
// When the receiver stalls, every stage holds and in_ready_o drops, so no item
// is lost or repeated. Reset clears all valid bits and loads the default
// registers: NOE mode and both gains equal to 1.0.
module restraint_energy_well_score_core (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [1:0]                                 cfg_idx_i,
  input  logic [rews_pkg::GAIN_W-1:0]                cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       distance_valid_i,
  input  logic [rews_pkg::DIST_W-1:0]                measured_distance_i,
  input  logic [rews_pkg::DIST_W-1:0]                lower_bound_i,
  input  logic [rews_pkg::DIST_W-1:0]                upper_bound_i,
  input  logic [rews_pkg::DIST_W-1:0]                expected_distance_i,
  input  logic                                       bond_valid_i,
  input  logic [rews_pkg::BOND_W-1:0]                bond_count_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [rews_pkg::SCORE_W-1:0]        score_o,
  output logic                                       order_error_o
);
  import rews_pkg::*;

  localparam cos_tab_t HalfCos = build_cos_table();
  localparam logic [39:0] Unit40 = 40'(1 << FRAC_BITS);
  localparam logic [39:0] SatLimit = 40'(64'(32'h7FFF_FFFF) + (64'd1 << FRAC_BITS));

  logic mode_q;
  logic [GAIN_W-1:0] k2_q, k3_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      k2_q   <= GAIN_W'(1 << FRAC_BITS);
      k3_q   <= GAIN_W'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WELL_MODE:  mode_q <= cfg_wdata_i[0];
        CFG_LOWER_GAIN: k2_q   <= cfg_wdata_i;
        CFG_UPPER_GAIN: k3_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1.
  logic  v1;
  geom_t g1;

  rews_geom u_geom (
    .clk_i,
    .rst_ni,
    .en_i                (en),
    .valid_i             (in_valid_i),
    .mode_i              (mode_q),
    .distance_valid_i,
    .measured_distance_i,
    .lower_bound_i,
    .upper_bound_i,
    .expected_distance_i,
    .bond_valid_i,
    .bond_count_i,
    .valid_o             (v1),
    .geom_o              (g1)
  );

  // Stage 2: segment and multiplier operands.
  logic signed [RW-1:0] xs;
  seg_e seg_d;
  logic [DIST_W-1:0] da_d, span_d, past_d;
  logic [OFF_W-1:0] off_d;
  logic signed [RW-1:0] dlo, dhi, dspan, dpast, doff1;

  always_comb begin
    xs    = RW'(g1.x);
    dlo   = g1.r2 - xs;
    dhi   = xs - g1.r3;
    dspan = g1.r4 - g1.r3;
    dpast = xs - g1.r4;
    doff1 = xs - g1.r1;
    da_d  = '0;
    off_d = '0;
    span_d = dspan[DIST_W-1:0];
    past_d = '0;
    if (!g1.mode) begin
      if (xs < g1.r2) begin
        seg_d = SEG_LOW_WALL;
        da_d  = dlo[DIST_W-1:0];
      end else if (xs < g1.r3) begin
        seg_d = SEG_FLAT;
      end else if (xs < g1.r4) begin
        seg_d = SEG_HIGH_WALL;
        da_d  = dhi[DIST_W-1:0];
      end else begin
        seg_d  = SEG_HIGH_LINE;
        da_d   = dspan[DIST_W-1:0];
        past_d = dpast[DIST_W-1:0];
      end
    end else begin
      if (xs < g1.r1 || xs >= g1.r4) begin
        seg_d = SEG_ONE;
      end else if (xs < g1.r2) begin
        seg_d = SEG_COS_RISE;
        off_d = doff1[OFF_W-1:0];
      end else if (xs < g1.r3) begin
        seg_d = SEG_FLAT;
      end else begin
        seg_d = SEG_COS_FALL;
        off_d = dhi[OFF_W-1:0];
      end
    end
  end

  logic v2_q, inval2_q, err2_q;
  seg_e seg2_q;
  logic [DIST_W-1:0] da2_q, span2_q, past2_q;
  logic [OFF_W-1:0] off2_q;
  logic [GAIN_W-1:0] k2s_q;

  // Stage 3: squares, slope product and cosine index.
  logic [2*DIST_W-1:0] sq_full, sl_full;
  logic [OFF_W:0] off_rnd;
  logic [11:0] m_idx;
  logic [26:0] q_idx;

  always_comb begin
    sq_full = {{DIST_W{1'b0}}, da2_q} * {{DIST_W{1'b0}}, da2_q};
    sl_full = {{DIST_W{1'b0}}, span2_q} * {{DIST_W{1'b0}}, past2_q};
    // Rounded index (off + w/2D) / (w/D) with w/D = 3840 = 256 * 15.
    off_rnd = {1'b0, off2_q} + (OFF_W+1)'(1920);
    m_idx   = off_rnd[19:8];
    q_idx   = {15'd0, m_idx} * 27'd17477;
  end

  logic v3_q, inval3_q, err3_q;
  seg_e seg3_q;
  logic [29:0] sq3_q, sl3_q;
  logic [IDX_W-1:0] idx3_q;
  logic [GAIN_W-1:0] k3s_q;

  // Stage 4: gain products and table lookup.
  logic [53:0] a_full, b_full;

  always_comb begin
    a_full = {30'd0, k3s_q} * {24'd0, sq3_q};
    b_full = {30'd0, k3s_q} * {24'd0, sl3_q};
  end

  logic v4_q, inval4_q, err4_q;
  seg_e seg4_q;
  logic [37:0] a4_q, b4_q;
  logic [COS_W-1:0] t4_q;

  // Stage 5: well value, offset and saturation.
  logic [39:0] v5, diff5;
  logic signed [SCORE_W-1:0] score_d;

  always_comb begin
    case (seg4_q)
      SEG_LOW_WALL, SEG_HIGH_WALL: v5 = {2'b0, a4_q};
      SEG_HIGH_LINE:               v5 = {2'b0, a4_q} + {1'b0, b4_q, 1'b0};
      SEG_ONE:                     v5 = Unit40;
      SEG_COS_RISE:                v5 = {{(40-COS_W){1'b0}}, t4_q};
      SEG_COS_FALL:                v5 = Unit40 - {{(40-COS_W){1'b0}}, t4_q};
      default:                     v5 = '0;
    endcase
    diff5 = v5 - Unit40;
    if (inval4_q || err4_q) score_d = '0;
    else if (v5 > SatLimit) score_d = 32'sh7FFF_FFFF;
    else score_d = $signed(diff5[SCORE_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v2_q        <= v1;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inval2_q <= g1.inval;
      err2_q   <= g1.err;
      seg2_q   <= seg_d;
      da2_q    <= da_d;
      span2_q  <= span_d;
      past2_q  <= past_d;
      off2_q   <= off_d;
      k2s_q    <= (seg_d == SEG_LOW_WALL) ? k2_q : k3_q;

      inval3_q <= inval2_q;
      err3_q   <= err2_q;
      seg3_q   <= seg2_q;
      sq3_q    <= sq_full[45:16];
      sl3_q    <= sl_full[45:16];
      idx3_q   <= q_idx[26:18];
      k3s_q    <= k2s_q;

      inval4_q <= inval3_q;
      err4_q   <= err3_q;
      seg4_q   <= seg3_q;
      a4_q     <= a_full[53:16];
      b4_q     <= b_full[53:16];
      t4_q     <= HalfCos[idx3_q];

      score_o       <= score_d;
      order_error_o <= err4_q && !inval4_q;
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && order_error_o) |-> (score_o == '0))
    else $error("order error with nonzero score");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (score_o >= -32'sd65536))
    else $error("score below minus one");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en) |=> out_valid_o)
    else $error("item lost at output register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 && !en) |=> v1)
    else $error("first stage dropped a stalled item");

endmodule
